@@ rtl/rqs_pkg.sv @@
// Package for the read quality statistics block: sizes, codes, state type.
// No dependencies; rqs_div and the core import it.
package rqs_pkg;

  localparam int MAX_READ_LEN = 512;
  localparam int QUAL_BINS    = 64;
  localparam int GC_SCALE     = 1024;
  localparam int POS_ENTRIES  = MAX_READ_LEN * 8;
  localparam int GC_ENTRIES   = GC_SCALE + 1;
  localparam int KMER_ENTRIES = 1024;
  localparam int SCALAR_COUNT = 5;

  localparam int POS_AW  = $clog2(POS_ENTRIES);
  localparam int LEN_AW  = $clog2(MAX_READ_LEN);
  localparam int GC_AW   = $clog2(GC_ENTRIES);
  localparam int QB_AW   = $clog2(QUAL_BINS);
  localparam int KMER_AW = $clog2(KMER_ENTRIES);
  localparam int RPOS_W  = $clog2(MAX_READ_LEN + 1);
  localparam int QTOT_W  = 18;
  localparam int DIV_W   = 20;
  localparam int CLR_W   = POS_AW;

  localparam logic [7:0]  UNKNOWN_BASE = 8'h4E;
  localparam logic [6:0]  PHRED_RESET  = 7'd33;
  localparam logic [15:0] CODE_RESET   = 16'd49536;
  localparam logic [2:0]  GUARD_RESET  = 3'd4;
  localparam logic [2:0]  GUARD_SET    = 3'd5;
  localparam logic [7:0]  Q20          = 8'd20;
  localparam logic [7:0]  Q30          = 8'd30;

  localparam logic [0:0] OP_PUSH = 1'b0;
  localparam logic [0:0] OP_READ = 1'b1;

  localparam logic [3:0] REG_PHRED = 4'd0;
  localparam logic [3:0] REG_CODE  = 4'd1;

  localparam logic [2:0] TBL_POS_COUNT = 3'd0;
  localparam logic [2:0] TBL_POS_QUAL  = 3'd1;
  localparam logic [2:0] TBL_LENGTH    = 3'd2;
  localparam logic [2:0] TBL_GC        = 3'd3;
  localparam logic [2:0] TBL_MEANQ     = 3'd4;
  localparam logic [2:0] TBL_KMER      = 3'd5;
  localparam logic [2:0] TBL_SCALAR    = 3'd6;

  localparam int SC_READS = 0;
  localparam int SC_BASES = 1;
  localparam int SC_GC    = 2;
  localparam int SC_Q20   = 3;
  localparam int SC_Q30   = 4;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PUSH_RD, S_PUSH_WB, S_GC_GO, S_GC_WAIT,
    S_Q_GO, S_Q_WAIT, S_FIN_RD, S_FIN_WB, S_RDO_RD, S_RDO_WB
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

@@ rtl/rqs_in_if.sv @@
// Input request channel: valid/ready plus one base or readout request.
// Depends on nothing.
interface rqs_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  base_char;
  logic [7:0]  quality_char;
  logic        read_end;
  logic [2:0]  table_select;
  logic [11:0] entry_index;
  modport source (output valid, op, base_char, quality_char, read_end, table_select,
                  entry_index, input ready);
  modport sink (input valid, op, base_char, quality_char, read_end, table_select,
                entry_index, output ready);
endinterface

@@ rtl/rqs_out_if.sv @@
// Result channel: valid/ready plus one statistics entry.
// Depends on nothing.
interface rqs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] entry_value;
  logic        index_invalid;
  modport source (output valid, entry_value, index_invalid, input ready);
  modport sink (input valid, entry_value, index_invalid, output ready);
endinterface

@@ rtl/rqs_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and write data.
// Depends on nothing.
interface rqs_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/rqs_ram.sv @@
// Generic single write, single read synchronous RAM with registered read data.
// Depends on nothing.
module rqs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we && (32'(waddr) < DEPTH)) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

@@ rtl/rqs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the read-end bins.
// Depends on rqs_pkg.
module rqs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rqs_pkg::div_ctl_t         ctl_in,
  output rqs_pkg::div_ctl_t         ctl_out,
  input  logic [rqs_pkg::DIV_W-1:0] dividend,
  input  logic [rqs_pkg::RPOS_W-1:0] divisor,
  output logic [rqs_pkg::DIV_W-1:0] quotient
);
  import rqs_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [RPOS_W-1:0] rem_r, rem_nxt;
  logic [RPOS_W:0]   rem_sh;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic              take;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    take     = rem_sh >= {1'b0, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (ctl_in.start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = CNT_W'(DIV_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = take ? RPOS_W'(rem_sh - {1'b0, divisor}) : rem_sh[RPOS_W-1:0];
      quo_nxt  = {quo_r[DIV_W-2:0], take};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient      = quo_r;
  assign ctl_out.done  = done_r;
  assign ctl_out.start = 1'b0;
endmodule

@@ rtl/read_quality_statistics_core.sv @@
// Read quality statistics: per-base read-modify-write of histogram RAMs.
// Push: each base is a RAM read, then a write-back; a read end adds two
// divisions on one shared divider, then a histogram update. Readout: a RAM
// read, then a load of the output register. After reset a clearing pass
// zeroes all RAMs; no request is taken during it, configuration writes are.
module read_quality_statistics_core (
  input logic clk,
  input logic rst_n,
  rqs_in_if.sink    in_ch,
  rqs_out_if.source out_ch,
  rqs_cfg_if.sink   cfg_ch
);
  import rqs_pkg::*;

  state_t state_r, state_nxt;

  logic [CLR_W-1:0] clr_r;
  logic [6:0]  phred_r;
  logic [15:0] code_tbl_r;

  logic        op_r, last_r;
  logic [7:0]  base_r, qchar_r;
  logic [2:0]  tbl_r;
  logic [11:0] idx_r;

  logic [RPOS_W-1:0] read_pos_r;
  logic [RPOS_W-1:0] gc_cnt_r;
  logic [QTOT_W-1:0] qtot_r;
  logic [KMER_AW-1:0] kshift_r;
  logic [2:0]  kguard_r;
  logic [63:0] scalar_r [SCALAR_COUNT];

  logic [POS_AW-1:0]  slot_r;
  logic [7:0]         q_r;
  logic [KMER_AW-1:0] kaddr_r;
  logic               khit_r;
  logic [GC_AW-1:0]   gbin_r;
  logic [QB_AW-1:0]   qbin_r;

  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic        out_inv_r;

  // push datapath
  logic [2:0]  low;
  logic [7:0]  q;
  logic [1:0]  code;
  logic [2:0]  guard_eff, guard_new;
  logic [KMER_AW-1:0] kshift_new;
  logic        active, is_gc;
  logic [RPOS_W-1:0] len;

  // control
  logic in_ready, clearing, push_re, fin_re, rdo_re, rdo_load;
  div_ctl_t div_req, div_rsp;
  logic [DIV_W-1:0] div_dividend, div_quo;

  // RAM ports
  logic [63:0] pc_rd, pq_rd, ln_rd, gc_rd, mq_rd, km_rd;
  logic pc_we, ln_we, km_we;
  logic [POS_AW-1:0]  pc_raddr, pc_waddr;
  logic [LEN_AW-1:0]  ln_addr, ln_raddr;
  logic [GC_AW-1:0]   gc_addr, gc_raddr;
  logic [QB_AW-1:0]   mq_addr, mq_raddr;
  logic [KMER_AW-1:0] km_raddr, km_waddr;
  logic [63:0] pc_wdata, pq_wdata, ln_wdata, gc_wdata, mq_wdata, km_wdata;

  logic [63:0] rdo_value;
  logic        rdo_inv;

  always_comb begin
    low        = base_r[2:0];
    q          = (qchar_r > {1'b0, phred_r}) ? (qchar_r - {1'b0, phred_r}) : 8'd0;
    code       = code_tbl_r[{low, 1'b0} +: 2];
    is_gc      = (low == 3'd3) || (low == 3'd7);
    active     = read_pos_r < RPOS_W'(MAX_READ_LEN);
    guard_eff  = (base_r == UNKNOWN_BASE) ? GUARD_SET : kguard_r;
    guard_new  = (guard_eff == 3'd0) ? 3'd0 : guard_eff - 3'd1;
    kshift_new = {kshift_r[KMER_AW-3:0], code};
    len        = (read_pos_r == '0) ? RPOS_W'(1) : read_pos_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:   if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE:    if (in_ch.valid) state_nxt = (in_ch.op == OP_READ) ? S_RDO_RD : S_PUSH_RD;
      S_PUSH_RD: begin
        if (active) state_nxt = S_PUSH_WB;
        else state_nxt = last_r ? S_GC_GO : S_IDLE;
      end
      S_PUSH_WB: state_nxt = last_r ? S_GC_GO : S_IDLE;
      S_GC_GO:   state_nxt = S_GC_WAIT;
      S_GC_WAIT: if (div_rsp.done) state_nxt = S_Q_GO;
      S_Q_GO:    state_nxt = S_Q_WAIT;
      S_Q_WAIT:  if (div_rsp.done) state_nxt = S_FIN_RD;
      S_FIN_RD:  state_nxt = S_FIN_WB;
      S_FIN_WB:  state_nxt = S_IDLE;
      S_RDO_RD:  state_nxt = S_RDO_WB;
      S_RDO_WB:  if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready      = 1'b0;
    clearing      = 1'b0;
    push_re       = 1'b0;
    fin_re        = 1'b0;
    rdo_re        = 1'b0;
    rdo_load      = 1'b0;
    div_req.start = 1'b0;
    div_req.done  = 1'b0;
    div_dividend  = DIV_W'(qtot_r);
    unique case (state_r)
      S_CLEAR:   clearing = 1'b1;
      S_IDLE:    in_ready = 1'b1;
      S_PUSH_RD: push_re = active;
      S_GC_GO: begin
        div_req.start = 1'b1;
        div_dividend  = DIV_W'(gc_cnt_r) * DIV_W'(GC_SCALE);
      end
      S_Q_GO:    div_req.start = 1'b1;
      S_FIN_RD:  fin_re = 1'b1;
      S_RDO_RD:  rdo_re = 1'b1;
      S_RDO_WB:  rdo_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // RAM addressing
  always_comb begin
    pc_raddr = rdo_re ? idx_r[POS_AW-1:0] : {read_pos_r[LEN_AW-1:0], low};
    km_raddr = rdo_re ? idx_r[KMER_AW-1:0] : kshift_new;
    ln_raddr = rdo_re ? idx_r[LEN_AW-1:0] : LEN_AW'(len - RPOS_W'(1));
    gc_raddr = rdo_re ? idx_r[GC_AW-1:0] : gbin_r;
    mq_raddr = rdo_re ? idx_r[QB_AW-1:0] : qbin_r;

    pc_we    = clearing || (state_r == S_PUSH_WB);
    km_we    = clearing || ((state_r == S_PUSH_WB) && khit_r);
    ln_we    = clearing || (state_r == S_FIN_WB);
    pc_waddr = clearing ? clr_r[POS_AW-1:0] : slot_r;
    km_waddr = clearing ? clr_r[KMER_AW-1:0] : kaddr_r;
    ln_addr  = clearing ? clr_r[LEN_AW-1:0] : ln_raddr;
    gc_addr  = clearing ? clr_r[GC_AW-1:0] : gbin_r;
    mq_addr  = clearing ? clr_r[QB_AW-1:0] : qbin_r;
    pc_wdata = clearing ? 64'd0 : pc_rd + 64'd1;
    pq_wdata = clearing ? 64'd0 : pq_rd + 64'(q_r);
    km_wdata = clearing ? 64'd0 : km_rd + 64'd1;
    ln_wdata = clearing ? 64'd0 : ln_rd + 64'd1;
    gc_wdata = clearing ? 64'd0 : gc_rd + 64'd1;
    mq_wdata = clearing ? 64'd0 : mq_rd + 64'd1;
  end

  rqs_ram #(.DEPTH(POS_ENTRIES), .WIDTH(64)) u_pos_count (
    .clk, .we(pc_we), .waddr(pc_waddr), .wdata(pc_wdata),
    .re(push_re || rdo_re), .raddr(pc_raddr), .rdata(pc_rd));
  rqs_ram #(.DEPTH(POS_ENTRIES), .WIDTH(64)) u_pos_qual (
    .clk, .we(pc_we), .waddr(pc_waddr), .wdata(pq_wdata),
    .re(push_re || rdo_re), .raddr(pc_raddr), .rdata(pq_rd));
  rqs_ram #(.DEPTH(KMER_ENTRIES), .WIDTH(64)) u_kmer (
    .clk, .we(km_we), .waddr(km_waddr), .wdata(km_wdata),
    .re(push_re || rdo_re), .raddr(km_raddr), .rdata(km_rd));
  rqs_ram #(.DEPTH(MAX_READ_LEN), .WIDTH(64)) u_length (
    .clk, .we(ln_we), .waddr(ln_addr), .wdata(ln_wdata),
    .re(fin_re || rdo_re), .raddr(ln_raddr), .rdata(ln_rd));
  rqs_ram #(.DEPTH(GC_ENTRIES), .WIDTH(64)) u_gc (
    .clk, .we(ln_we), .waddr(gc_addr), .wdata(gc_wdata),
    .re(fin_re || rdo_re), .raddr(gc_raddr), .rdata(gc_rd));
  rqs_ram #(.DEPTH(QUAL_BINS), .WIDTH(64)) u_meanq (
    .clk, .we(ln_we), .waddr(mq_addr), .wdata(mq_wdata),
    .re(fin_re || rdo_re), .raddr(mq_raddr), .rdata(mq_rd));

  rqs_div u_div (
    .clk, .rst_n, .ctl_in(div_req), .ctl_out(div_rsp),
    .dividend(div_dividend), .divisor(len), .quotient(div_quo));

  // readout selection
  always_comb begin
    rdo_value = 64'd0;
    rdo_inv   = 1'b0;
    unique case (tbl_r)
      TBL_POS_COUNT: rdo_value = pc_rd;
      TBL_POS_QUAL:  rdo_value = pq_rd;
      TBL_LENGTH:    begin
        rdo_inv = idx_r >= 12'(MAX_READ_LEN);
        rdo_value = ln_rd;
      end
      TBL_GC:        begin
        rdo_inv = idx_r >= 12'(GC_ENTRIES);
        rdo_value = gc_rd;
      end
      TBL_MEANQ:     begin
        rdo_inv = idx_r >= 12'(QUAL_BINS);
        rdo_value = mq_rd;
      end
      TBL_KMER:      begin
        rdo_inv = idx_r >= 12'(KMER_ENTRIES);
        rdo_value = km_rd;
      end
      TBL_SCALAR:    begin
        rdo_inv = idx_r >= 12'(SCALAR_COUNT);
        if (!rdo_inv) rdo_value = scalar_r[idx_r[2:0]];
      end
      default:       rdo_inv = 1'b1;
    endcase
    if (rdo_inv) rdo_value = 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      phred_r     <= PHRED_RESET;
      code_tbl_r  <= CODE_RESET;
      read_pos_r  <= '0;
      gc_cnt_r    <= '0;
      qtot_r      <= '0;
      kshift_r    <= '0;
      kguard_r    <= GUARD_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SCALAR_COUNT; i++) scalar_r[i] <= 64'd0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_r <= clr_r + 1'b1;
      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_PHRED) phred_r <= cfg_ch.data[6:0];
        if (cfg_ch.index == REG_CODE) code_tbl_r <= cfg_ch.data;
      end
      if (push_re) begin
        read_pos_r <= read_pos_r + 1'b1;
        gc_cnt_r   <= gc_cnt_r + RPOS_W'(is_gc);
        qtot_r     <= qtot_r + QTOT_W'(q);
        kshift_r   <= kshift_new;
        kguard_r   <= guard_new;
        if (q >= Q20) scalar_r[SC_Q20] <= scalar_r[SC_Q20] + 64'd1;
        if (q >= Q30) scalar_r[SC_Q30] <= scalar_r[SC_Q30] + 64'd1;
      end
      if (state_r == S_FIN_WB) begin
        scalar_r[SC_READS] <= scalar_r[SC_READS] + 64'd1;
        scalar_r[SC_BASES] <= scalar_r[SC_BASES] + 64'(len);
        scalar_r[SC_GC]    <= scalar_r[SC_GC] + 64'(gc_cnt_r);
        read_pos_r <= '0;
        gc_cnt_r   <= '0;
        qtot_r     <= '0;
        kshift_r   <= '0;
        kguard_r   <= GUARD_RESET;
      end
      if (rdo_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
    if (in_ready && in_ch.valid) begin
      op_r    <= in_ch.op;
      base_r  <= in_ch.base_char;
      qchar_r <= in_ch.quality_char;
      last_r  <= in_ch.read_end;
      tbl_r   <= in_ch.table_select;
      idx_r   <= in_ch.entry_index;
    end
    if (push_re) begin
      slot_r  <= {read_pos_r[LEN_AW-1:0], low};
      q_r     <= q;
      kaddr_r <= kshift_new;
      khit_r  <= (guard_eff == 3'd0);
    end
    if ((state_r == S_GC_WAIT) && div_rsp.done)
      gbin_r <= (div_quo > DIV_W'(GC_SCALE)) ? GC_AW'(GC_SCALE) : div_quo[GC_AW-1:0];
    if ((state_r == S_Q_WAIT) && div_rsp.done)
      qbin_r <= (div_quo > DIV_W'(QUAL_BINS - 1)) ? QB_AW'(QUAL_BINS - 1)
                                                  : div_quo[QB_AW-1:0];
    if (rdo_load) begin
      out_value_r <= rdo_value;
      out_inv_r   <= rdo_inv;
    end
  end

  assign in_ch.ready          = in_ready;
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.entry_value   = out_value_r;
  assign out_ch.index_invalid = out_inv_r;

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ch.ready) else $error("request taken while clearing");
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_GC_WAIT || state_r == S_Q_WAIT))
    else $error("divider finished outside a wait state");
  a_guard_range: assert property (@(posedge clk) disable iff (!rst_n)
    kguard_r <= GUARD_SET) else $error("k-mer guard out of range");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    read_pos_r <= RPOS_W'(MAX_READ_LEN)) else $error("read position past maximum");
  a_op_route: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDO_RD) |-> (op_r == OP_READ)) else $error("push routed to readout");
endmodule
